// File: sv/fwr_pkg.sv
// ----------------------------------------------------------------------------
// fwr_pkg: shared types and constants for the full-weighting restriction
// Result coordinates, front-end status and the depth of the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package fwr_pkg;

  // width of the coarse row and column indices on the result port
  localparam int unsigned CoordW = 9;

  // slots in the queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;

  // lowest level and reset level of the configuration register
  localparam logic [3:0] LevelMin   = 4'd2;
  localparam logic [3:0] LevelReset = 4'd10;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic              last;
  } coord_t;

  localparam int unsigned CoordBits = $bits(coord_t);

  // words still inside the front that will claim a queue slot
  typedef struct packed {
    logic s1_emit;
    logic s2_emit;
  } front_stat_t;

endpackage : fwr_pkg

`default_nettype wire

// File: sv/fwr_front.sv
// ----------------------------------------------------------------------------
// fwr_front: raster tracking, line stores, 3x3 window and partial sums
// Classifies each fine sample and pushes partial sums for coarse points.
// ----------------------------------------------------------------------------
`default_nettype none

module fwr_front
  import fwr_pkg::*;
#(
  parameter int unsigned MAX_LEVEL    = 10,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic [SAMPLE_WIDTH-1:0]   sample,
  input  wire logic                      cfg_wr_en,
  input  wire logic [3:0]                cfg_fine_level,
  output      logic                      push,
  output      logic [3*(SAMPLE_WIDTH+4)+CoordBits-1:0] push_data,
  output      front_stat_t               stat
);

  localparam int unsigned SW        = SAMPLE_WIDTH;
  localparam int unsigned EW        = SAMPLE_WIDTH + 4;
  localparam int unsigned CW        = MAX_LEVEL + 1;
  localparam int unsigned LineDepth = (1 << MAX_LEVEL) + 1;
  localparam logic [3:0]  LevelMax  = 4'(MAX_LEVEL);

  logic [3:0]    level_r;
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;

  logic [3:0]    eff_level;
  logic [CW-1:0] nm1, nm2;
  logic          emit0, last0;
  logic [CW-1:0] rm1, cm1;
  logic [CW+CoordW-1:0] row_ext, col_ext;
  coord_t        coord0;

  // effective level and grid limits
  always_comb begin
    if (level_r < LevelMin) begin
      eff_level = LevelMin;
    end else if (level_r > LevelMax) begin
      eff_level = LevelMax;
    end else begin
      eff_level = level_r;
    end
  end

  assign nm1 = CW'(1) << eff_level;
  assign nm2 = nm1 - CW'(1);

  assign emit0 = (row_r >= CW'(3)) && (col_r >= CW'(3)) && row_r[0] && col_r[0]
                 && (row_r <= nm2) && (col_r <= nm2);
  assign last0 = (row_r == nm2) && (col_r == nm2);

  assign rm1     = row_r - CW'(1);
  assign cm1     = col_r - CW'(1);
  assign row_ext = {{CoordW{1'b0}}, rm1 >> 1};
  assign col_ext = {{CoordW{1'b0}}, cm1 >> 1};
  assign coord0  = '{row: row_ext[CoordW-1:0], col: col_ext[CoordW-1:0], last: last0};

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (col_r >= nm1) begin
      col_nxt = '0;
      row_nxt = (row_r >= nm1) ? '0 : row_r + CW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LevelReset;
      row_r   <= '0;
      col_r   <= '0;
    end else if (cfg_wr_en) begin
      level_r <= cfg_fine_level;
      row_r   <= '0;
      col_r   <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // stage 1: line store read
  logic [SW-1:0] older_mem [LineDepth];
  logic [SW-1:0] newer_mem [LineDepth];
  logic [SW-1:0] top_r, mid_r;
  logic          s1_v_r, s1_emit_r;
  logic [SW-1:0] s1_sample_r;
  logic [CW-1:0] s1_addr_r;
  coord_t        s1_coord_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      top_r <= older_mem[col_r];
      mid_r <= newer_mem[col_r];
    end
    if (s1_v_r) begin
      older_mem[s1_addr_r] <= mid_r;
      newer_mem[s1_addr_r] <= s1_sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_emit_r <= 1'b0;
    end else begin
      s1_v_r    <= accept;
      s1_emit_r <= accept && emit0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r <= sample;
      s1_addr_r   <= col_r;
      s1_coord_r  <= coord0;
    end
  end

  // stage 2: window shift and partial sums
  logic [SW-1:0] win_r [6];
  logic [EW-1:0] x0, x1, x2, x3, x4, x5, xt, xm, xs;
  logic [EW-1:0] e15, e2m, c0t, c4s;
  logic [EW-1:0] p0_nxt, p1_nxt, p2_nxt;
  logic [EW-1:0] p0_r, p1_r, p2_r;
  logic          s2_v_r;
  coord_t        s2_coord_r;

  assign x0 = {{4{win_r[0][SW-1]}}, win_r[0]};
  assign x1 = {{4{win_r[1][SW-1]}}, win_r[1]};
  assign x2 = {{4{win_r[2][SW-1]}}, win_r[2]};
  assign x3 = {{4{win_r[3][SW-1]}}, win_r[3]};
  assign x4 = {{4{win_r[4][SW-1]}}, win_r[4]};
  assign x5 = {{4{win_r[5][SW-1]}}, win_r[5]};
  assign xt = {{4{top_r[SW-1]}}, top_r};
  assign xm = {{4{mid_r[SW-1]}}, mid_r};
  assign xs = {{4{s1_sample_r[SW-1]}}, s1_sample_r};

  assign e15 = x1 + x5;
  assign e2m = x2 + xm;
  assign c0t = x0 + xt;
  assign c4s = x4 + xs;

  // centre weighted 4, edges 2, corners 1
  assign p0_nxt = {x3[EW-3:0], 2'b00} + {e15[EW-2:0], 1'b0};
  assign p1_nxt = {e2m[EW-2:0], 1'b0} + c0t;
  assign p2_nxt = c4s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_v_r) begin
      win_r[0] <= win_r[1];
      win_r[1] <= top_r;
      win_r[2] <= win_r[3];
      win_r[3] <= mid_r;
      win_r[4] <= win_r[5];
      win_r[5] <= s1_sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit_r) begin
      p0_r       <= p0_nxt;
      p1_r       <= p1_nxt;
      p2_r       <= p2_nxt;
      s2_coord_r <= s1_coord_r;
    end
  end

  assign push         = s2_v_r;
  assign push_data    = {p0_r, p1_r, p2_r, s2_coord_r};
  assign stat.s1_emit = s1_emit_r;
  assign stat.s2_emit = s2_v_r;

endmodule : fwr_front

`default_nettype wire

// File: sv/fwr_queue.sv
// ----------------------------------------------------------------------------
// fwr_queue: short queue of partial-sum words between front and back
// Register array with read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module fwr_queue
  import fwr_pkg::*;
#(
  parameter int unsigned WIDTH = 127
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output      logic             valid,
  output      logic [WIDTH-1:0] head,
  output      logic [QCntW-1:0] count
);

  logic [WIDTH-1:0] slot_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + QCntW'(1);
        2'b01:   count_r <= count_r - QCntW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign valid = (count_r != '0);
  assign head  = slot_r[rd_ptr_r];
  assign count = count_r;

endmodule : fwr_queue

`default_nettype wire

// File: sv/fwr_back.sv
// ----------------------------------------------------------------------------
// fwr_back: final sum, divide by sixteen, and result register
// Adds the three partial sums and holds the result until popped.
// ----------------------------------------------------------------------------
`default_nettype none

module fwr_back
  import fwr_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    q_valid,
  input  wire logic [3*(SAMPLE_WIDTH+4)+CoordBits-1:0] q_head,
  output      logic                                    q_pop,
  output      logic                                    out_valid,
  output      logic [SAMPLE_WIDTH-1:0]                 out_rhs,
  output      coord_t                                  out_coord,
  input  wire logic                                    out_pop
);

  localparam int unsigned EW = SAMPLE_WIDTH + 4;

  logic [EW-1:0]           p0, p1, p2, sum;
  coord_t                  coord;
  logic                    valid_r;
  logic [SAMPLE_WIDTH-1:0] rhs_r;
  coord_t                  coord_r;

  assign {p0, p1, p2, coord} = q_head;
  assign sum = p0 + p1 + p2;

  // load when the result register is free or being emptied
  assign q_pop = q_valid && (!valid_r || out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  // arithmetic shift by four: drop the low bits of the exact sum
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rhs_r   <= sum[EW-1:4];
      coord_r <= coord;
    end
  end

  assign out_valid = valid_r;
  assign out_rhs   = rhs_r;
  assign out_coord = coord_r;

endmodule : fwr_back

`default_nettype wire

// File: sv/full_weighting_restriction_2d.sv
// ----------------------------------------------------------------------------
// full_weighting_restriction_2d: streaming 2D multigrid restriction
// Fine residual samples in, full-weighted coarse right-hand side out.
// ----------------------------------------------------------------------------
// Push fine-grid residual samples (signed Q16.16) in row-major raster order;
// the grid side is 2^fine_level+1. The block takes one word per clock while
// in_full is low and gives one result word for every interior coarse point,
// in raster order, tagged with its coarse row and column and a last_of_grid
// flag on the final one. Each result is (4*centre + 2*edges + corners) >> 4
// over the 3x3 fine neighbourhood, floored. The sample that completes one
// result passes the line store read, the window and partial sums, the queue
// and the result register, in that order. The rate is set by the line stores,
// one read and one write port each, touched once per sample. in_full rises
// only when the four-entry queue, plus the words still in the front stages,
// would run out of room, i.e. when the consumer stops popping. Writing
// fine_level (only while idle) restarts the grid at row 0, column 0; levels
// below 2 act as 2 and levels above MAX_LEVEL act as MAX_LEVEL. The line
// stores need no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module full_weighting_restriction_2d
  import fwr_pkg::*;
#(
  parameter int unsigned MAX_LEVEL    = 10,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input word channel
  input  wire logic                           in_push,
  output      logic                           in_full,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_residual_sample,
  // result word channel
  output      logic                           out_empty,
  input  wire logic                           out_pop,
  output      logic signed [SAMPLE_WIDTH-1:0] out_coarse_rhs,
  output      logic [CoordW-1:0]              out_coarse_row,
  output      logic [CoordW-1:0]              out_coarse_col,
  output      logic                           out_last_of_grid,
  // configuration
  input  wire logic                           cfg_wr_en,
  input  wire logic [3:0]                     cfg_fine_level
);

  localparam int unsigned QW = 3 * (SAMPLE_WIDTH + 4) + CoordBits;

  logic                    accept;
  logic                    f_push;
  logic [QW-1:0]           f_data;
  front_stat_t             f_stat;
  logic                    q_valid, q_pop;
  logic [QW-1:0]           q_head;
  logic [QCntW-1:0]        q_count;
  logic [QCntW:0]          claimed;
  logic                    b_valid;
  logic [SAMPLE_WIDTH-1:0] b_rhs;
  coord_t                  b_coord;

  // hold off input once queued plus in-flight words could fill the queue
  assign claimed = {1'b0, q_count} + (QCntW+1)'(f_stat.s1_emit)
                   + (QCntW+1)'(f_stat.s2_emit);
  assign in_full = (claimed >= (QCntW+1)'(QDepth));
  assign accept  = in_push && !in_full;

  fwr_front #(
    .MAX_LEVEL    (MAX_LEVEL),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .sample         (in_residual_sample),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_fine_level (cfg_fine_level),
    .push           (f_push),
    .push_data      (f_data),
    .stat           (f_stat)
  );

  fwr_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (f_data),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head),
    .count     (q_count)
  );

  fwr_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (b_valid),
    .out_rhs   (b_rhs),
    .out_coord (b_coord),
    .out_pop   (out_pop)
  );

  assign out_empty        = !b_valid;
  assign out_coarse_rhs   = b_rhs;
  assign out_coarse_row   = b_coord.row;
  assign out_coarse_col   = b_coord.col;
  assign out_last_of_grid = b_coord.last;

  // the credit check must keep the queue from overflowing
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (f_push && !q_pop) |-> (q_count < QCntW'(QDepth)))
    else $error("queue written while full");

  // back loads a word only when the result register is free or leaving
  a_back_load: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (out_empty || out_pop))
    else $error("result register overwritten");

  // the final coarse point sits on the diagonal
  a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last_of_grid) |-> (out_coarse_row == out_coarse_col))
    else $error("last_of_grid off the diagonal");

  // input is held off whenever the queue count shows the queue full
  a_full_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count == QCntW'(QDepth)) |-> in_full)
    else $error("input open with queue full");

endmodule : full_weighting_restriction_2d

`default_nettype wire
